// ===== src/ogu_pkg.sv =====
// Package for the offset guided 2x upscaler.
// Holds the controller state type, the command and status structs, register codes
// and the blend arithmetic. It depends on nothing.
package ogu_pkg;

  localparam int unsigned Q15_MAX      = 32767;
  localparam int unsigned HEIGHT_LIMIT = 2048;
  localparam logic [11:0] WIDTH_RESET  = 12'd640;
  localparam logic [11:0] HEIGHT_RESET = 12'd480;

  localparam logic REG_IMAGE_WIDTH  = 1'b0;
  localparam logic REG_IMAGE_HEIGHT = 1'b1;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_LOAD,
    ST_BLEND,
    ST_EMIT
  } state_t;

  typedef struct packed {
    logic       accept;
    logic       load;
    logic       blend;
    logic [1:0] step;
    logic       advance;
  } cmd_t;

  typedef struct packed {
    logic last;
  } status_t;

  // Magnitude of a Q15 offset; the most negative code saturates.
  function automatic logic [14:0] weight_of(input logic [15:0] raw);
    logic [15:0] neg;
    neg = 16'(~raw + 16'd1);
    if (raw == 16'h8000) begin
      return 15'(Q15_MAX);
    end else if (raw[15]) begin
      return neg[14:0];
    end else begin
      return raw[14:0];
    end
  endfunction

  // Per byte lerp from a toward b by c/32767, truncated. The division by
  // 32767 is exact for sums below 256*32767: q = (s + (s >> 15) + 1) >> 15.
  function automatic logic [31:0] blend(input logic [31:0] a, input logic [31:0] b,
                                        input logic [14:0] c);
    logic [31:0] res;
    logic [14:0] ci;
    logic [23:0] s;
    logic [23:0] t;
    ci  = 15'(Q15_MAX) - c;
    res = '0;
    for (int ch = 0; ch < 4; ch++) begin
      s = 24'(a[ch*8 +: 8] * ci) + 24'(b[ch*8 +: 8] * c);
      t = s + (s >> 15) + 24'd1;
      res[ch*8 +: 8] = t[22:15];
    end
    return res;
  endfunction

endpackage

// ===== src/ogu_if.sv =====
// Stream interfaces for the offset guided 2x upscaler: input pixels and results.
// Both carry valid, ready and the payload; no package is needed.
interface ogu_in_if;
  logic               valid;
  logic               ready;
  logic        [31:0] pixel_color;
  logic signed [15:0] offset_x;
  logic signed [15:0] offset_y;

  modport source (output valid, pixel_color, offset_x, offset_y, input ready);
  modport sink (input valid, pixel_color, offset_x, offset_y, output ready);
endinterface

interface ogu_out_if;
  logic        valid;
  logic        ready;
  logic [11:0] out_column;
  logic [11:0] out_row;
  logic [31:0] out_color;
  logic        run_last;

  modport source (output valid, out_column, out_row, out_color, run_last, input ready);
  modport sink (input valid, out_column, out_row, out_color, run_last, output ready);
endinterface

// ===== src/ogu_ctrl.sv =====
// Controller of the offset guided 2x upscaler: sequences accept, line store load,
// four blend steps and result emission. Depends on ogu_pkg.
module ogu_ctrl (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             in_valid,
  output logic             in_ready,
  output logic             out_valid,
  input  logic             out_ready,
  input  ogu_pkg::status_t status,
  output ogu_pkg::cmd_t    cmd
);

  ogu_pkg::state_t state_r, state_nxt;
  logic [1:0]      step_r, step_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ogu_pkg::ST_IDLE;
      step_r  <= '0;
    end else begin
      state_r <= state_nxt;
      step_r  <= step_nxt;
    end
  end

  always_comb begin
    state_nxt   = state_r;
    step_nxt    = step_r;
    in_ready    = 1'b0;
    out_valid   = 1'b0;
    cmd         = '0;
    cmd.step    = step_r;
    unique case (state_r)
      ogu_pkg::ST_IDLE: begin
        in_ready   = 1'b1;
        cmd.accept = in_valid;
        if (in_valid) begin
          state_nxt = ogu_pkg::ST_LOAD;
        end
      end
      ogu_pkg::ST_LOAD: begin
        cmd.load  = 1'b1;
        step_nxt  = '0;
        state_nxt = ogu_pkg::ST_BLEND;
      end
      ogu_pkg::ST_BLEND: begin
        cmd.blend = 1'b1;
        step_nxt  = step_r + 2'd1;
        if (step_r == 2'd3) begin
          state_nxt = ogu_pkg::ST_EMIT;
        end
      end
      ogu_pkg::ST_EMIT: begin
        out_valid   = 1'b1;
        cmd.advance = out_ready;
        if (out_ready && status.last) begin
          state_nxt = ogu_pkg::ST_IDLE;
        end
      end
      default: state_nxt = ogu_pkg::ST_IDLE;
    endcase
  end

  a_accept_loads: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.accept |=> state_r == ogu_pkg::ST_LOAD) else $error("accept not followed by load");
  a_load_blends: assert property (@(posedge clk) disable iff (!rst_n)
    state_r == ogu_pkg::ST_LOAD |=> state_r == ogu_pkg::ST_BLEND && step_r == 2'd0)
    else $error("load not followed by first blend step");
  a_last_idles: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_ready && status.last |=> state_r == ogu_pkg::ST_IDLE)
    else $error("last result did not return to idle");
  a_no_overlap: assert property (@(posedge clk) disable iff (!rst_n)
    !(in_ready && out_valid)) else $error("input taken while results pending");

endmodule

// ===== src/ogu_datapath.sv =====
// Datapath of the offset guided 2x upscaler: configuration, counters, line store,
// the shared blend unit and the result selection. Depends on ogu_pkg.
module ogu_datapath #(
  parameter int MAX_WIDTH = 2048
) (
  input  logic               clk,
  input  logic               rst_n,
  input  ogu_pkg::cmd_t      cmd,
  output ogu_pkg::status_t   status,
  input  logic               cfg_we,
  input  logic               cfg_index,
  input  logic        [11:0] cfg_data,
  input  logic        [31:0] pixel_color,
  input  logic signed [15:0] offset_x,
  input  logic signed [15:0] offset_y,
  output logic        [11:0] out_column,
  output logic        [11:0] out_row,
  output logic        [31:0] out_color,
  output logic               run_last
);

  localparam int XW = (MAX_WIDTH > 1) ? $clog2(MAX_WIDTH) : 1;
  localparam int EW = (XW + 2 > 14) ? XW + 2 : 14;
  localparam int YW = $clog2(ogu_pkg::HEIGHT_LIMIT);

  logic [11:0]   width_r, height_r;
  logic [XW-1:0] col_r, x_r;
  logic [YW-1:0] row_r, y_r;
  logic [31:0]   color_r, left_r, ul_pix_r;
  logic [31:0]   offs_r, ul_off_r;
  logic [63:0]   rd_r;
  logic [31:0]   c00_r, c01_r, c10_r, c11_r;
  logic [14:0]   wx_r, wy_r;
  logic          negx_r, negy_r;
  logic [7:0]    mask_r;
  logic [2:0]    idx;
  logic [63:0]   mem [MAX_WIDTH];

  logic [EW-1:0] w_eff, h_eff;
  logic [XW-1:0] x_cur;
  logic [YW-1:0] y_cur;

  always_comb begin
    w_eff = (width_r == 12'd0) ? EW'(1) : EW'(width_r);
    if (w_eff > EW'(MAX_WIDTH)) begin
      w_eff = EW'(MAX_WIDTH);
    end
    h_eff = (height_r == 12'd0) ? EW'(1) : EW'(height_r);
    if (h_eff > EW'(ogu_pkg::HEIGHT_LIMIT)) begin
      h_eff = EW'(ogu_pkg::HEIGHT_LIMIT);
    end
    // A counter left beyond a shrunk size restarts at zero.
    x_cur = (EW'(col_r) >= w_eff) ? '0 : col_r;
    y_cur = (EW'(row_r) >= h_eff) ? '0 : row_r;
  end

  // Edge flags of the four pixels at (2x..2x+1, 2y..2y+1), and the block flag.
  logic [3:0]    edge_bits;
  logic [EW-1:0] oc, orow;
  logic          has_block;
  always_comb begin
    has_block = (x_r != '0) && (y_r != '0);
    for (int d = 0; d < 4; d++) begin
      oc   = EW'({x_r, 1'b0}) + EW'(d & 1);
      orow = EW'({y_r, 1'b0}) + EW'(d >> 1);
      edge_bits[d] = (oc == '0) || (oc == (w_eff << 1) - EW'(1)) ||
                     (orow == '0) || (orow == (h_eff << 1) - EW'(1));
    end
  end

  // Shared blend unit: one 32-bit lerp per step.
  logic [31:0] bl_a, bl_b, bl_res;
  logic [14:0] bl_w;
  always_comb begin
    case (cmd.step)
      2'd0: begin
        bl_a = negx_r ? c00_r : c01_r;
        bl_b = negx_r ? c01_r : c00_r;
      end
      2'd1: begin
        bl_a = negx_r ? c10_r : c11_r;
        bl_b = negx_r ? c11_r : c10_r;
      end
      2'd2: begin
        bl_a = negy_r ? c00_r : c10_r;
        bl_b = negy_r ? c10_r : c00_r;
      end
      default: begin
        bl_a = negy_r ? c01_r : c11_r;
        bl_b = negy_r ? c11_r : c01_r;
      end
    endcase
    bl_w   = cmd.step[1] ? wy_r : wx_r;
    bl_res = ogu_pkg::blend(bl_a, bl_b, bl_w);
  end

  always_ff @(posedge clk) begin
    if (cmd.accept) begin
      rd_r <= mem[x_cur];
    end
    if (cmd.load) begin
      mem[x_r] <= {offs_r, color_r};
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      width_r  <= ogu_pkg::WIDTH_RESET;
      height_r <= ogu_pkg::HEIGHT_RESET;
      col_r    <= '0;
      row_r    <= '0;
      left_r   <= '0;
      ul_pix_r <= '0;
      ul_off_r <= '0;
      mask_r   <= '0;
    end else begin
      if (cfg_we) begin
        unique case (cfg_index)
          ogu_pkg::REG_IMAGE_WIDTH:  width_r  <= cfg_data;
          ogu_pkg::REG_IMAGE_HEIGHT: height_r <= cfg_data;
          default: ;
        endcase
      end
      if (cmd.load) begin
        ul_pix_r <= rd_r[31:0];
        ul_off_r <= rd_r[63:32];
        left_r   <= color_r;
        mask_r   <= {edge_bits, {4{has_block}}};
        if (EW'(x_r) + EW'(1) >= w_eff) begin
          col_r <= '0;
          row_r <= (EW'(y_r) + EW'(1) >= h_eff) ? '0 : y_r + YW'(1);
        end else begin
          col_r <= x_r + XW'(1);
        end
      end else if (cmd.advance) begin
        mask_r[idx] <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.accept) begin
      x_r     <= x_cur;
      y_r     <= y_cur;
      color_r <= pixel_color;
      offs_r  <= {offset_y, offset_x};
    end
    if (cmd.load) begin
      c00_r  <= ul_pix_r;
      c01_r  <= rd_r[31:0];
      c10_r  <= left_r;
      c11_r  <= color_r;
      wx_r   <= ogu_pkg::weight_of(ul_off_r[15:0]);
      wy_r   <= ogu_pkg::weight_of(ul_off_r[31:16]);
      negx_r <= ul_off_r[15];
      negy_r <= ul_off_r[31];
    end else if (cmd.blend) begin
      case (cmd.step)
        2'd0: if (negx_r) c00_r <= bl_res; else c01_r <= bl_res;
        2'd1: if (negx_r) c10_r <= bl_res; else c11_r <= bl_res;
        2'd2: if (negy_r) c00_r <= bl_res; else c10_r <= bl_res;
        default: if (negy_r) c01_r <= bl_res; else c11_r <= bl_res;
      endcase
    end
  end

  // Result selection: the lowest pending entry of the list goes out first.
  logic [11:0] base_col, base_row, adj;
  always_comb begin
    idx = '0;
    for (int i = 7; i >= 0; i--) begin
      if (mask_r[i]) begin
        idx = 3'(i);
      end
    end
    status.last = ($countones(mask_r) == 1);
    run_last    = status.last;
    base_col    = 12'({x_r, 1'b0});
    base_row    = 12'({y_r, 1'b0});
    adj         = idx[2] ? 12'd0 : 12'd1;
    out_column  = base_col + 12'(idx[0]) - adj;
    out_row     = base_row + 12'(idx[1]) - adj;
    if (idx[2]) begin
      out_color = color_r;
    end else begin
      case (idx[1:0])
        2'd0:    out_color = c00_r;
        2'd1:    out_color = c01_r;
        2'd2:    out_color = c10_r;
        default: out_color = c11_r;
      endcase
    end
  end

endmodule

// ===== src/offset_guided_upscale_2x.sv =====
// Top level of the offset guided 2x upscaler: controller plus datapath.
// Depends on ogu_pkg, ogu_if, ogu_ctrl and ogu_datapath.
//
//   channel   direction  handshake        payload
//   in_ch     in         valid / ready    pixel_color, offset_x, offset_y
//   out_ch    out        valid / ready    out_column, out_row, out_color, run_last
//   cfg       in         cfg_we           cfg_index, cfg_data
//
// Each item gives 1..7 results. Its steps: accept, line store read, four
// steps of the shared blend unit, then one result per cycle if out_ch is ready.
// Reset sets 640 x 480 and clears counters and neighbor pixels; the line
// store is not cleared. A stall on out_ch holds the current result, and
// in_ch stays not ready until the last result of the item is taken.
module offset_guided_upscale_2x #(
  parameter int MAX_WIDTH = 2048
) (
  input  logic        clk,
  input  logic        rst_n,
  ogu_in_if.sink      in_ch,
  ogu_out_if.source   out_ch,
  input  logic        cfg_we,
  input  logic        cfg_index,
  input  logic [11:0] cfg_data
);

  ogu_pkg::cmd_t    cmd;
  ogu_pkg::status_t status;

  ogu_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_ch.valid),
    .in_ready  (in_ch.ready),
    .out_valid (out_ch.valid),
    .out_ready (out_ch.ready),
    .status    (status),
    .cmd       (cmd)
  );

  ogu_datapath #(.MAX_WIDTH(MAX_WIDTH)) u_dp (
    .clk         (clk),
    .rst_n       (rst_n),
    .cmd         (cmd),
    .status      (status),
    .cfg_we      (cfg_we),
    .cfg_index   (cfg_index),
    .cfg_data    (cfg_data),
    .pixel_color (in_ch.pixel_color),
    .offset_x    (in_ch.offset_x),
    .offset_y    (in_ch.offset_y),
    .out_column  (out_ch.out_column),
    .out_row     (out_ch.out_row),
    .out_color   (out_ch.out_color),
    .run_last    (out_ch.run_last)
  );

endmodule
